// ----- hw/rtl/parallel_io_port_controller_defines.svh -----
// Assertion macros for the checker file of the parallel I/O controller.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef PARALLEL_IO_PORT_CONTROLLER_DEFINES_SVH
`define PARALLEL_IO_PORT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pioc_pkg.sv -----
// Shared types and constants of the parallel I/O controller.
// No dependencies; used by pioc_port, the top level and the bench.
package pioc_pkg;

  typedef enum logic [3:0] {
    OP_CPU_READ    = 4'd0,
    OP_CPU_WRITE   = 4'd1,
    OP_EXT_WRITE_A = 4'd2,
    OP_EXT_WRITE_B = 4'd3,
    OP_STROBE_A    = 4'd4,
    OP_STROBE_B    = 4'd5,
    OP_SET_IEI     = 4'd6,
    OP_INT_ACK     = 4'd7,
    OP_RETI        = 4'd8
  } pioc_op_e;

  typedef enum logic [1:0] {
    SEL_A_DATA = 2'd0,
    SEL_A_CTRL = 2'd1,
    SEL_B_DATA = 2'd2,
    SEL_B_CTRL = 2'd3
  } pioc_sel_e;

  typedef enum logic [1:0] {
    MODE_OUTPUT = 2'd0,
    MODE_INPUT  = 2'd1,
    MODE_BIDIR  = 2'd2,
    MODE_BIT    = 2'd3
  } pioc_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DIR  = 2'd1,
    PH_MASK = 2'd2
  } pioc_phase_e;

  // Control word low-nibble codes
  localparam logic [3:0] CW_MODE      = 4'hF;
  localparam logic [3:0] CW_IRQ_LONG  = 4'h7;
  localparam logic [3:0] CW_IRQ_SHORT = 4'h3;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;

  // Per-port command for one beat
  typedef struct packed {
    logic ctrl_we;
    logic data_we;
    logic ext_we;
    logic strobe;
    logic force_bit;
    logic chain_we;
    logic chain_val;
    logic ack;
    logic reti;
  } pioc_cmd_t;

  // Per-port status: current state plus the post-beat view used for results
  typedef struct packed {
    pioc_mode_e mode_q;
    logic       pend_q;
    logic       svc_q;
    logic       chain_q;
    logic [7:0] vector_q;
    logic [7:0] rd_data;
    pioc_mode_e mode_d;
    logic       pend_d;
    logic       chain_d;
    logic [7:0] pins_d;
  } pioc_stat_t;

endpackage

// ----- hw/rtl/parallel_io_port_controller.sv -----
// Two-port parallel I/O controller, top level. Uses pioc_pkg and pioc_port.
// The result of a beat is registered and shown in the cycle after it is accepted.
// Throughput: one beat per cycle; the single result register stalls input
// only while a result waits and out_ready_i is low.
// Reset (rst_ni low, async): both ports in input mode, masks, vectors and
// latches zero, no interrupt pending or in service, chain enables set.
module parallel_io_port_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beat
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] opcode_i,
  input  logic [1:0] port_sel_i,
  input  logic [7:0] data_i,
  input  logic       level_i,
  // result beat
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [7:0] vector_o,
  output logic       drive_a_o,
  output logic       drive_b_o,
  output logic [7:0] drive_data_o,
  output logic [7:0] pins_a_o,
  output logic [7:0] pins_b_o,
  output logic       int_request_o,
  output logic       ieo_o
);

  logic in_fire;

  pioc_pkg::pioc_cmd_t  cmd_a, cmd_b;
  pioc_pkg::pioc_stat_t stat_a, stat_b;

  // acknowledge / return-from-interrupt priority: port A first
  logic ack_a, ack_b, reti_a, reti_b;

  // result register
  logic       out_valid_q;
  logic [7:0] read_data_q, read_data_d;
  logic [7:0] vector_q, vector_d;
  logic       drive_a_q, drive_a_d, drive_b_q, drive_b_d;
  logic [7:0] drive_data_q, drive_data_d;
  logic [7:0] pins_a_q, pins_b_q;
  logic       int_request_q, int_request_d, ieo_q, ieo_d;
  logic       req_a, req_b;

  // The result register parts the two sides: a new beat enters whenever
  // the held result is empty or being taken this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ack_a  = stat_a.chain_q && stat_a.pend_q && !stat_a.svc_q;
  assign ack_b  = !ack_a && stat_b.chain_q && stat_b.pend_q && !stat_b.svc_q;
  assign reti_a = stat_a.chain_q && stat_a.svc_q;
  assign reti_b = !reti_a && stat_b.chain_q && stat_b.svc_q;

  // Command decode: everything gated by the input handshake.
  always_comb begin
    cmd_a = '0;
    cmd_b = '0;
    if (in_fire) begin
      case (pioc_pkg::pioc_op_e'(opcode_i))
        pioc_pkg::OP_CPU_WRITE: begin
          case (pioc_pkg::pioc_sel_e'(port_sel_i))
            pioc_pkg::SEL_A_DATA: cmd_a.data_we = 1'b1;
            pioc_pkg::SEL_A_CTRL: cmd_a.ctrl_we = 1'b1;
            pioc_pkg::SEL_B_DATA: cmd_b.data_we = 1'b1;
            pioc_pkg::SEL_B_CTRL: cmd_b.ctrl_we = 1'b1;
            default: ;
          endcase
        end
        pioc_pkg::OP_EXT_WRITE_A: cmd_a.ext_we = 1'b1;
        pioc_pkg::OP_EXT_WRITE_B: cmd_b.ext_we = 1'b1;
        // strobe on a falling edge only; the mode gate differs per port
        pioc_pkg::OP_STROBE_A: begin
          cmd_a.strobe = !level_i && (stat_a.mode_q != pioc_pkg::MODE_BIT);
        end
        pioc_pkg::OP_STROBE_B: begin
          cmd_b.strobe = !level_i && (stat_b.mode_q == pioc_pkg::MODE_INPUT ||
                                      stat_b.mode_q == pioc_pkg::MODE_BIT);
        end
        // port B enable samples port A activity only at this moment
        pioc_pkg::OP_SET_IEI: begin
          cmd_a.chain_we  = 1'b1;
          cmd_a.chain_val = level_i;
          cmd_b.chain_we  = 1'b1;
          cmd_b.chain_val = level_i && !(stat_a.pend_q || stat_a.svc_q);
        end
        pioc_pkg::OP_INT_ACK: begin
          cmd_a.ack = ack_a;
          cmd_b.ack = ack_b;
        end
        pioc_pkg::OP_RETI: begin
          cmd_a.reti = reti_a;
          cmd_b.reti = reti_b;
        end
        default: ;
      endcase
    end
    // port A in bidirectional mode pulls port B into bit mode after any
    // control write
    cmd_b.force_bit = (cmd_a.ctrl_we || cmd_b.ctrl_we) &&
                      (stat_a.mode_d == pioc_pkg::MODE_BIDIR);
  end

  pioc_port u_port_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_a),
    .data_i (data_i),
    .stat_o (stat_a)
  );

  pioc_port u_port_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_b),
    .data_i (data_i),
    .stat_o (stat_b)
  );

  // Result of the beat, from the post-beat state.
  always_comb begin
    read_data_d = 8'h00;
    if (pioc_pkg::pioc_op_e'(opcode_i) == pioc_pkg::OP_CPU_READ) begin
      case (pioc_pkg::pioc_sel_e'(port_sel_i))
        pioc_pkg::SEL_A_DATA: read_data_d = stat_a.rd_data;
        pioc_pkg::SEL_B_DATA: read_data_d = stat_b.rd_data;
        default:              read_data_d = pioc_pkg::BYTE_ONES;
      endcase
    end
  end

  always_comb begin
    if (cmd_a.ack) begin
      vector_d = stat_a.vector_q;
    end else if (cmd_b.ack) begin
      vector_d = stat_b.vector_q;
    end else begin
      vector_d = pioc_pkg::BYTE_ONES;
    end
  end

  // data write drives the pins unless the port is in input mode
  assign drive_a_d    = cmd_a.data_we && (stat_a.mode_q != pioc_pkg::MODE_INPUT);
  assign drive_b_d    = cmd_b.data_we && (stat_b.mode_q != pioc_pkg::MODE_INPUT);
  assign drive_data_d = (drive_a_d || drive_b_d) ? data_i : 8'h00;

  assign req_a         = stat_a.chain_d && stat_a.pend_d;
  assign req_b         = stat_b.chain_d && stat_b.pend_d;
  assign int_request_d = req_a || req_b;
  assign ieo_d         = int_request_d ? 1'b0 : stat_a.chain_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // payload register, loaded only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_data_q   <= read_data_d;
      vector_q      <= vector_d;
      drive_a_q     <= drive_a_d;
      drive_b_q     <= drive_b_d;
      drive_data_q  <= drive_data_d;
      pins_a_q      <= stat_a.pins_d;
      pins_b_q      <= stat_b.pins_d;
      int_request_q <= int_request_d;
      ieo_q         <= ieo_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign vector_o      = vector_q;
  assign drive_a_o     = drive_a_q;
  assign drive_b_o     = drive_b_q;
  assign drive_data_o  = drive_data_q;
  assign pins_a_o      = pins_a_q;
  assign pins_b_o      = pins_b_q;
  assign int_request_o = int_request_q;
  assign ieo_o         = ieo_q;

endmodule

// ----- hw/rtl/pioc_port.sv -----
// One port of the parallel I/O controller: control word decoder, latches,
// interrupt logic and chain enable. Depends on pioc_pkg.
module pioc_port (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pioc_pkg::pioc_cmd_t   cmd_i,
  input  logic [7:0]            data_i,
  output pioc_pkg::pioc_stat_t  stat_o
);

  pioc_pkg::pioc_mode_e  mode_q, mode_d;
  pioc_pkg::pioc_phase_e phase_q, phase_d;
  logic [7:0] dir_q, dir_d, imask_q, imask_d, vec_q, vec_d;
  logic [7:0] out_q, out_d, in_q, in_d;
  logic       ien_q, ien_d, and_q, and_d, ahi_q, ahi_d;
  logic       pend_q, pend_d, svc_q, svc_d, chain_q, chain_d;
  logic [7:0] open_bits, act_bits;
  logic       hit;
  logic [7:0] rd_data, pin_drive;

  // bit-mode interrupt match over unmasked bits
  assign open_bits = ~imask_q;
  assign act_bits  = data_i & open_bits;
  always_comb begin
    if (and_q) begin
      hit = (act_bits == (ahi_q ? open_bits : 8'h00));
    end else begin
      hit = ahi_q ? (act_bits != 8'h00) : (act_bits != open_bits);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    dir_d   = dir_q;
    imask_d = imask_q;
    vec_d   = vec_q;
    out_d   = out_q;
    in_d    = in_q;
    ien_d   = ien_q;
    and_d   = and_q;
    ahi_d   = ahi_q;
    pend_d  = pend_q;
    svc_d   = svc_q;
    chain_d = chain_q;

    if (cmd_i.data_we) begin
      out_d = data_i;
    end

    if (cmd_i.ctrl_we) begin
      case (phase_q)
        pioc_pkg::PH_DIR: begin
          dir_d   = data_i;
          phase_d = pioc_pkg::PH_IDLE;
        end
        pioc_pkg::PH_MASK: begin
          imask_d = data_i;
          phase_d = pioc_pkg::PH_IDLE;
        end
        default: begin
          phase_d = pioc_pkg::PH_IDLE;
          if (!data_i[0]) begin
            vec_d = data_i;
          end else if (data_i[3:0] == pioc_pkg::CW_MODE) begin
            mode_d = pioc_pkg::pioc_mode_e'(data_i[7:6]);
            if (data_i[7:6] == pioc_pkg::MODE_BIT) begin
              phase_d = pioc_pkg::PH_DIR;
            end
          end else if (data_i[3:0] == pioc_pkg::CW_IRQ_LONG ||
                       data_i[3:0] == pioc_pkg::CW_IRQ_SHORT) begin
            ien_d = data_i[7];
            and_d = data_i[6];
            ahi_d = data_i[5];
            if (data_i[3:0] == pioc_pkg::CW_IRQ_LONG && data_i[4]) begin
              phase_d = pioc_pkg::PH_MASK;
            end
          end
        end
      endcase
    end

    // forced bit mode keeps the control phase as it is
    if (cmd_i.force_bit) begin
      mode_d = pioc_pkg::MODE_BIT;
    end

    if (cmd_i.ext_we) begin
      in_d = data_i;
      if (ien_q) begin
        case (mode_q)
          pioc_pkg::MODE_INPUT, pioc_pkg::MODE_BIDIR: pend_d = 1'b1;
          pioc_pkg::MODE_BIT: begin
            if (hit) pend_d = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.strobe && ien_q) begin
      pend_d = 1'b1;
    end

    if (cmd_i.chain_we) begin
      chain_d = cmd_i.chain_val;
    end

    if (cmd_i.ack) begin
      pend_d = 1'b0;
      svc_d  = 1'b1;
    end

    if (cmd_i.reti) begin
      svc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pioc_pkg::MODE_INPUT;
      phase_q <= pioc_pkg::PH_IDLE;
      dir_q   <= 8'h00;
      imask_q <= 8'h00;
      vec_q   <= 8'h00;
      out_q   <= 8'h00;
      in_q    <= 8'h00;
      ien_q   <= 1'b0;
      and_q   <= 1'b0;
      ahi_q   <= 1'b0;
      pend_q  <= 1'b0;
      svc_q   <= 1'b0;
      chain_q <= 1'b1;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      dir_q   <= dir_d;
      imask_q <= imask_d;
      vec_q   <= vec_d;
      out_q   <= out_d;
      in_q    <= in_d;
      ien_q   <= ien_d;
      and_q   <= and_d;
      ahi_q   <= ahi_d;
      pend_q  <= pend_d;
      svc_q   <= svc_d;
      chain_q <= chain_d;
    end
  end

  // read data: a read beat changes nothing, so current state is the post view
  always_comb begin
    case (mode_q)
      pioc_pkg::MODE_OUTPUT: rd_data = out_q;
      pioc_pkg::MODE_BIT:    rd_data = (in_q & dir_q) | (out_q & ~dir_q);
      default:               rd_data = in_q;
    endcase
  end

  always_comb begin
    case (mode_d)
      pioc_pkg::MODE_INPUT: pin_drive = pioc_pkg::BYTE_ONES;
      pioc_pkg::MODE_BIT:   pin_drive = out_d & ~dir_d;
      default:              pin_drive = out_d;
    endcase
  end

  assign stat_o = '{
    mode_q:   mode_q,
    pend_q:   pend_q,
    svc_q:    svc_q,
    chain_q:  chain_q,
    vector_q: vec_q,
    rd_data:  rd_data,
    mode_d:   mode_d,
    pend_d:   pend_d,
    chain_d:  chain_d,
    pins_d:   pin_drive
  };

endmodule

// ----- hw/rtl/pioc_checker.sv -----
// Port-level checker for the parallel I/O controller, bound to the top level.
// Depends on parallel_io_port_controller_defines.svh.
`include "parallel_io_port_controller_defines.svh"

module pioc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic       drive_a_o,
  input logic       drive_b_o,
  input logic       int_request_o,
  input logic       ieo_o
);

  `PIOC_ASSERT_NEXT(a_beat_gives_result, in_valid_i && in_ready_o, out_valid_o, "accepted beat gave no result")
  `PIOC_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(read_data_o), "stalled result changed")
  `PIOC_ASSERT_NOW(a_req_blocks_chain, out_valid_o && int_request_o, !ieo_o, "ieo high with request")
  `PIOC_ASSERT_NOW(a_one_drive, out_valid_o, !(drive_a_o && drive_b_o), "both ports driven in one beat")

endmodule

bind parallel_io_port_controller pioc_checker u_pioc_checker (.*);

// ----- verif/tb_parallel_io_port_controller.sv -----
// Self-checking bench for parallel_io_port_controller: directed table, then random beats.
// Each accepted beat runs through a beat-level copy of the port state to predict its result.
// Depends on pioc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_parallel_io_port_controller;
  import pioc_pkg::*;

  // Opcodes the block does not decode
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

  localparam int RAND_BEATS   = 750;
  localparam int HOLD_AT      = 600;     // receiver cycle where the long hold-off starts
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] vec;
    logic       da;
    logic       db;
    logic [7:0] dd;
    logic [7:0] pa;
    logic [7:0] pb;
    logic       irq;
    logic       ieo;
  } pio_status_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  sel;
    logic [7:0]  data;
    logic        level;
    bit          fixed;   // want holds a hand-written result
    pio_status_t want;
  } pio_beat_t;

  // Status right after reset: both ports input, chain open, nothing pending
  localparam pio_status_t RESET_VIEW =
    '{8'h00, BYTE_ONES, 1'b0, 1'b0, 8'h00, BYTE_ONES, BYTE_ONES, 1'b0, 1'b1};
  localparam pio_status_t RESET_CTRL_READ =
    '{BYTE_ONES, BYTE_ONES, 1'b0, 1'b0, 8'h00, BYTE_ONES, BYTE_ONES, 1'b0, 1'b1};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] opcode_i = '0;
  logic [1:0] port_sel_i = '0;
  logic [7:0] data_i = '0;
  logic       level_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] read_data_o;
  logic [7:0] vector_o;
  logic       drive_a_o;
  logic       drive_b_o;
  logic [7:0] drive_data_o;
  logic [7:0] pins_a_o;
  logic [7:0] pins_b_o;
  logic       int_request_o;
  logic       ieo_o;

  parallel_io_port_controller dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Port state of the predictor, index 0 = port A, 1 = port B
  pioc_mode_e  mode_m   [2];
  pioc_phase_e phase_m  [2];
  logic [7:0]  dir_m    [2];
  logic [7:0]  imask_m  [2];
  logic [7:0]  ivec_m   [2];
  logic [7:0]  out_m    [2];
  logic [7:0]  in_m     [2];
  logic        ien_m    [2];
  logic        and_m    [2];
  logic        ahi_m    [2];
  logic        pend_m   [2];
  logic        svc_m    [2];
  logic        chain_m  [2];

  pio_beat_t   plan_q   [$];
  pio_status_t status_q [$];
  int          bad_cnt = 0;

  // Directed beats; hand-written results only where state is still at reset
  pio_beat_t dir_tab [25] = '{
    '{OP_CPU_READ,     SEL_A_DATA, 8'h00, 1'b0, 1'b1, RESET_VIEW},
    '{OP_CPU_READ,     SEL_A_CTRL, 8'h00, 1'b0, 1'b1, RESET_CTRL_READ},
    '{OP_UNUSED_LAST,  SEL_B_CTRL, 8'hFF, 1'b1, 1'b1, RESET_VIEW},
    '{OP_INT_ACK,      SEL_A_DATA, 8'h00, 1'b0, 1'b1, RESET_VIEW},
    '{OP_EXT_WRITE_A,  SEL_A_DATA, 8'hFF, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_A_CTRL, {MODE_OUTPUT, 2'b00, CW_MODE}, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_A_DATA, 8'hA5, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_A_CTRL, {MODE_BIT, 2'b11, CW_MODE}, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_A_CTRL, 8'hF0, 1'b0, 1'b0, '0},   // direction byte
    // enabled, OR logic, active high, mask byte follows
    '{OP_CPU_WRITE,    SEL_A_CTRL, {3'b101, 1'b1, CW_IRQ_LONG}, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_A_CTRL, 8'h0F, 1'b0, 1'b0, '0},   // mask byte
    '{OP_CPU_WRITE,    SEL_A_CTRL, 8'h40, 1'b0, 1'b0, '0},   // vector byte
    '{OP_CPU_READ,     SEL_A_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_EXT_WRITE_A,  SEL_A_DATA, 8'h10, 1'b0, 1'b0, '0},
    '{OP_STROBE_A,     SEL_A_DATA, 8'h00, 1'b1, 1'b0, '0},   // high level: no event
    '{OP_INT_ACK,      SEL_A_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_RETI,         SEL_A_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_CPU_WRITE,    SEL_B_CTRL, 8'h05, 1'b0, 1'b0, '0},   // undefined control word
    '{OP_CPU_WRITE,    SEL_B_CTRL, {3'b110, 1'b0, CW_IRQ_SHORT}, 1'b0, 1'b0, '0},
    '{OP_EXT_WRITE_B,  SEL_B_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_STROBE_B,     SEL_B_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_SET_IEI,      SEL_A_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_SET_IEI,      SEL_A_DATA, 8'h00, 1'b1, 1'b0, '0},
    // A bidirectional pulls B into bit mode
    '{OP_CPU_WRITE,    SEL_A_CTRL, {MODE_BIDIR, 2'b00, CW_MODE}, 1'b0, 1'b0, '0},
    '{OP_UNUSED_FIRST, SEL_A_DATA, 8'h5A, 1'b0, 1'b0, '0}
  };

  function automatic logic [7:0] port_read_val(int k);
    case (mode_m[k])
      MODE_OUTPUT: return out_m[k];
      MODE_BIT:    return (in_m[k] & dir_m[k]) | (out_m[k] & ~dir_m[k]);
      default:     return in_m[k];
    endcase
  endfunction

  function automatic logic [7:0] port_pins(int k);
    case (mode_m[k])
      MODE_INPUT: return BYTE_ONES;
      MODE_BIT:   return out_m[k] & ~dir_m[k];
      default:    return out_m[k];
    endcase
  endfunction

  // Pin-side write into the input latch, with interrupt match in bit mode
  function automatic void ext_latch(int k, logic [7:0] d);
    logic [7:0] open_bits;
    logic [7:0] act;
    logic       hit;
    in_m[k] = d;
    if (!ien_m[k]) return;
    if (mode_m[k] == MODE_INPUT || mode_m[k] == MODE_BIDIR) begin
      pend_m[k] = 1'b1;
      return;
    end
    if (mode_m[k] != MODE_BIT) return;
    open_bits = ~imask_m[k];
    act = d & open_bits;
    if (and_m[k]) hit = (act == (ahi_m[k] ? open_bits : 8'h00));
    else          hit = ahi_m[k] ? (act != 8'h00) : (act != open_bits);
    if (hit) pend_m[k] = 1'b1;
  endfunction

  // Applies one beat to the port state and returns the status it reports
  function automatic pio_status_t pio_apply_beat(logic [3:0] op, logic [1:0] sel,
                                                 logic [7:0] d, logic lvl);
    pio_status_t s;
    int          k;
    logic        found;
    logic        ra;
    logic        rb;
    s = '0;
    s.vec = BYTE_ONES;
    found = 1'b0;
    case (op)
      OP_CPU_READ: begin
        if (sel == SEL_A_DATA)      s.rd = port_read_val(0);
        else if (sel == SEL_B_DATA) s.rd = port_read_val(1);
        else                        s.rd = BYTE_ONES;
      end
      OP_CPU_WRITE: begin
        k = (sel == SEL_A_DATA || sel == SEL_A_CTRL) ? 0 : 1;
        if (sel == SEL_A_DATA || sel == SEL_B_DATA) begin
          out_m[k] = d;
          if (mode_m[k] != MODE_INPUT) begin
            if (k == 0) s.da = 1'b1;
            else        s.db = 1'b1;
            s.dd = d;
          end
        end else begin
          // control decoder: a pending follow-up byte takes precedence
          if (phase_m[k] == PH_DIR) begin
            dir_m[k] = d;
            phase_m[k] = PH_IDLE;
          end else if (phase_m[k] == PH_MASK) begin
            imask_m[k] = d;
            phase_m[k] = PH_IDLE;
          end else if (!d[0]) begin
            ivec_m[k] = d;
          end else if (d[3:0] == CW_MODE) begin
            mode_m[k] = pioc_mode_e'(d[7:6]);
            if (mode_m[k] == MODE_BIT) phase_m[k] = PH_DIR;
          end else if (d[3:0] == CW_IRQ_LONG || d[3:0] == CW_IRQ_SHORT) begin
            ien_m[k] = d[7];
            and_m[k] = d[6];
            ahi_m[k] = d[5];
            if (d[3:0] == CW_IRQ_LONG && d[4]) phase_m[k] = PH_MASK;
          end
          // forced bit mode never opens a direction phase
          if (mode_m[0] == MODE_BIDIR && mode_m[1] != MODE_BIT) mode_m[1] = MODE_BIT;
        end
      end
      OP_EXT_WRITE_A: ext_latch(0, d);
      OP_EXT_WRITE_B: ext_latch(1, d);
      OP_STROBE_A: begin
        if (!lvl && mode_m[0] != MODE_BIT && ien_m[0]) pend_m[0] = 1'b1;
      end
      OP_STROBE_B: begin
        if (!lvl && (mode_m[1] == MODE_INPUT || mode_m[1] == MODE_BIT) && ien_m[1])
          pend_m[1] = 1'b1;
      end
      OP_SET_IEI: begin
        // port B enable is sampled here only
        chain_m[0] = lvl;
        chain_m[1] = lvl && !(pend_m[0] || svc_m[0]);
      end
      OP_INT_ACK: begin
        for (int p = 0; p < 2; p++) begin
          if (!found && chain_m[p] && pend_m[p] && !svc_m[p]) begin
            pend_m[p] = 1'b0;
            svc_m[p] = 1'b1;
            s.vec = ivec_m[p];
            found = 1'b1;
          end
        end
      end
      OP_RETI: begin
        if (chain_m[0] && svc_m[0])      svc_m[0] = 1'b0;
        else if (chain_m[1] && svc_m[1]) svc_m[1] = 1'b0;
      end
      default: ;
    endcase
    ra = chain_m[0] && pend_m[0];
    rb = chain_m[1] && pend_m[1];
    s.pa = port_pins(0);
    s.pb = port_pins(1);
    s.irq = ra || rb;
    s.ieo = (ra || rb) ? 1'b0 : chain_m[0];
    return s;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic plan_beat(logic [3:0] op, logic [1:0] sel, logic [7:0] d, logic lvl);
    plan_q.push_back('{op, sel, d, lvl, 1'b0, '0});
  endtask

  // Sender: builds the plan, releases reset, then offers every beat
  initial begin : sender
    pio_beat_t   b;
    pio_status_t want;
    pioc_mode_e  m;
    logic [1:0]  csel;
    logic [7:0]  d;
    logic        en;
    logic        more;
    int          r;
    int          gap;

    for (int k = 0; k < 2; k++) begin
      mode_m[k] = MODE_INPUT;
      phase_m[k] = PH_IDLE;
      dir_m[k] = '0;
      imask_m[k] = '0;
      ivec_m[k] = '0;
      out_m[k] = '0;
      in_m[k] = '0;
      ien_m[k] = 1'b0;
      and_m[k] = 1'b0;
      ahi_m[k] = 1'b0;
      pend_m[k] = 1'b0;
      svc_m[k] = 1'b0;
      chain_m[k] = 1'b1;
    end

    foreach (dir_tab[i]) plan_q.push_back(dir_tab[i]);

    // Random part: mostly well-formed control sequences and pin traffic
    while (plan_q.size() < $size(dir_tab) + RAND_BEATS) begin
      r = $urandom_range(0, 99);
      csel = $urandom_range(0, 1) ? SEL_A_CTRL : SEL_B_CTRL;
      en = ($urandom_range(0, 4) != 0);
      if (r < 18) begin
        case ($urandom_range(0, 3))
          0: begin
            m = pioc_mode_e'($urandom_range(0, 3));
            // keep port A out of bidirectional most of the time
            if (m == MODE_BIDIR && csel == SEL_A_CTRL && $urandom_range(0, 2) != 0)
              m = pioc_mode_e'($urandom_range(0, 1));
            plan_beat(OP_CPU_WRITE, csel, {m, 2'($urandom_range(0, 3)), CW_MODE}, 1'b0);
            if (m == MODE_BIT) plan_beat(OP_CPU_WRITE, csel, 8'($urandom), 1'b0);
          end
          1: begin
            more = 1'($urandom_range(0, 1));
            plan_beat(OP_CPU_WRITE, csel,
                      {en, 2'($urandom_range(0, 3)), more, CW_IRQ_LONG}, 1'b0);
            if (more) plan_beat(OP_CPU_WRITE, csel, 8'($urandom), 1'b0);
          end
          2: plan_beat(OP_CPU_WRITE, csel,
                       {en, 3'($urandom_range(0, 7)), CW_IRQ_SHORT}, 1'b0);
          default: plan_beat(OP_CPU_WRITE, csel, {7'($urandom), 1'b0}, 1'b0);
        endcase
      end else if (r < 20 || r >= 97) begin
        plan_beat(OP_CPU_WRITE, csel, 8'($urandom), 1'($urandom));
      end else if (r < 30) begin
        plan_beat(OP_CPU_WRITE, $urandom_range(0, 1) ? SEL_A_DATA : SEL_B_DATA,
                  8'($urandom), 1'($urandom));
      end else if (r < 40) begin
        plan_beat(OP_CPU_READ, 2'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 64) begin
        // all-zero and all-one bytes hit the AND-logic match often
        case ($urandom_range(0, 3))
          0:       d = 8'h00;
          1:       d = BYTE_ONES;
          default: d = 8'($urandom);
        endcase
        plan_beat($urandom_range(0, 1) ? OP_EXT_WRITE_A : OP_EXT_WRITE_B,
                  2'($urandom), d, 1'($urandom));
      end else if (r < 72) begin
        plan_beat($urandom_range(0, 1) ? OP_STROBE_A : OP_STROBE_B, 2'($urandom),
                  8'($urandom), $urandom_range(0, 4) == 0);
      end else if (r < 82) begin
        plan_beat(OP_INT_ACK, 2'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 90) begin
        plan_beat(OP_RETI, 2'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 95) begin
        plan_beat(OP_SET_IEI, 2'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
      end else begin
        plan_beat(4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), 2'($urandom),
                  8'($urandom), 1'($urandom));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < plan_q.size(); i++) begin
      b = plan_q[i];
      // every fourth block of 128 beats goes without gaps
      gap = idle_len(((i / 128) % 4) == 2);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      opcode_i   <= b.op;
      port_sel_i <= b.sel;
      data_i     <= b.data;
      level_i    <= b.level;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      want = pio_apply_beat(b.op, b.sel, b.data, b.level);
      status_q.push_back(b.fixed ? b.want : want);
    end
    in_valid_i <= 1'b0;

    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0 && status_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off, and the result check
  initial begin : receiver
    pio_status_t got;
    pio_status_t want;
    int          stall_left;
    int          rx_cyc;
    int          beat_no;
    stall_left = 0;
    rx_cyc = 0;
    beat_no = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (out_valid_o && out_ready_i) begin
        got = '{read_data_o, vector_o, drive_a_o, drive_b_o, drive_data_o,
                pins_a_o, pins_b_o, int_request_o, ieo_o};
        if (status_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("result beat %0d arrived with none expected", beat_no);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("result beat %0d mismatch", beat_no);
              $display("  exp rd %h vec %h drv a%b b%b %h pins %h %h irq %b ieo %b",
                       want.rd, want.vec, want.da, want.db, want.dd,
                       want.pa, want.pb, want.irq, want.ieo);
              $display("  got rd %h vec %h drv a%b b%b %h pins %h %h irq %b ieo %b",
                       got.rd, got.vec, got.da, got.db, got.dd,
                       got.pa, got.pb, got.irq, got.ieo);
            end
          end
        end
        beat_no++;
      end
      // long hold-off lets the result register fill and stall the input side
      if (rx_cyc == HOLD_AT) stall_left = HOLD_LEN;
      else if (stall_left == 0) stall_left = idle_len(((rx_cyc / 256) % 4) == 1);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pioc_pkg.sv
hw/rtl/pioc_port.sv
hw/rtl/parallel_io_port_controller.sv
hw/rtl/pioc_checker.sv
verif/tb_parallel_io_port_controller.sv
